// ===== design/mmpq_pkg.sv =====
// Shared types and codes for the min/max priority queue.
package mmpq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE_MAX = 2'd1,
    OP_REMOVE_MIN = 2'd2,
    OP_SEARCH     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH,
    S_MOVE
  } state_e;

  typedef struct packed {
    logic clear;
    logic sample;
    logic largest;
  } scan_ctl_t;

  localparam int unsigned DataW = 32;

endpackage

// ===== design/mmpq_ram.sv =====
// Generic simple dual-port RAM with registered read.
module mmpq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mmpq_scan.sv =====
// Scan unit: tracks the extreme value, its index and a match flag over a sweep.
module mmpq_scan #(
  parameter int unsigned AddrW = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mmpq_pkg::scan_ctl_t        ctl_i,
  input  logic [AddrW-1:0]           idx_i,
  input  logic signed [31:0]         data_i,
  input  logic signed [31:0]         key_i,
  output logic signed [31:0]         best_val_o,
  output logic [AddrW-1:0]           best_idx_o,
  output logic                       found_o
);

  import mmpq_pkg::*;

  logic               have_q, have_d;
  logic               found_q, found_d;
  logic signed [31:0] best_val_q, best_val_d;
  logic [AddrW-1:0]   best_idx_q, best_idx_d;
  logic               better;

  always_comb begin
    better     = ctl_i.largest ? (data_i > best_val_q) : (data_i < best_val_q);
    have_d     = have_q;
    found_d    = found_q;
    best_val_d = best_val_q;
    best_idx_d = best_idx_q;
    if (ctl_i.clear) begin
      have_d  = 1'b0;
      found_d = 1'b0;
    end else if (ctl_i.sample) begin
      have_d = 1'b1;
      if (data_i == key_i) begin
        found_d = 1'b1;
      end
      if (!have_q || better) begin
        best_val_d = data_i;
        best_idx_d = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      have_q  <= have_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_val_q <= best_val_d;
    best_idx_q <= best_idx_d;
  end

  assign best_val_o = best_val_q;
  assign best_idx_o = best_idx_q;
  assign found_o    = found_q;

endmodule

// ===== design/min_max_priority_queue.sv =====
// Top level of the min/max priority queue over an unsorted RAM store.
//
//   channel   | ports                                        | handshake
//   ----------+----------------------------------------------+-------------------------
//   request   | operation_i, data_value_i                    | start && !busy
//   result    | result_value_o, status_o, entry_count_o      | done_o, one cycle, no stall
//
// Insert, and removal or search on an empty store, never raise busy; the result
// strobe follows in the next cycle. Remove and search sweep the N held entries
// through the RAM read port one per cycle and hold busy through the states
// S_SCAN, S_DRAIN and S_FINISH, and also S_MOVE when a removal refills the hole
// with the last entry. The strobe shows in the first cycle after busy drops.
// Reset empties the store at once.
// The receiver cannot stall: each result shows for exactly one cycle.
module min_max_priority_queue #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned AddrW = $clog2(CAPACITY),
  localparam int unsigned CntW  = $clog2(CAPACITY + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] data_value_i,
  output logic               done_o,
  output logic signed [31:0] result_value_o,
  output logic [1:0]         status_o,
  output logic [CntW-1:0]    entry_count_o
);

  import mmpq_pkg::*;

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic signed [31:0] key_q, key_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [AddrW-1:0]   addr_q, addr_d;
  logic               smp_q, smp_d;
  logic [AddrW-1:0]   smp_idx_q, smp_idx_d;
  logic               done_q, done_d;
  logic signed [31:0] res_q, res_d;
  status_e            status_q, status_d;

  logic               we;
  logic [AddrW-1:0]   waddr, raddr, last_addr;
  logic [DataW-1:0]   wdata, rdata;
  scan_ctl_t          scan_ctl;
  logic signed [31:0] best_val;
  logic [AddrW-1:0]   best_idx;
  logic               found;
  op_e                op_in;

  assign last_addr = AddrW'(count_q - 1'b1);
  assign op_in     = op_e'(operation_i);

  mmpq_ram #(
    .Width(DataW),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  mmpq_scan #(
    .AddrW(AddrW)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .idx_i     (smp_idx_q),
    .data_i    ($signed(rdata)),
    .key_i     (key_q),
    .best_val_o(best_val),
    .best_idx_o(best_idx),
    .found_o   (found)
  );

  always_comb begin
    state_d          = state_q;
    op_d             = op_q;
    key_d            = key_q;
    count_d          = count_q;
    addr_d           = addr_q;
    smp_d            = 1'b0;
    smp_idx_d        = addr_q;
    done_d           = 1'b0;
    res_d            = res_q;
    status_d         = status_q;
    we               = 1'b0;
    waddr            = AddrW'(count_q);
    wdata            = data_value_i;
    raddr            = addr_q;
    scan_ctl.clear   = 1'b0;
    scan_ctl.sample  = smp_q;
    scan_ctl.largest = (op_q == OP_REMOVE_MAX);
    busy             = (state_q != S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d           = op_in;
          key_d          = data_value_i;
          addr_d         = '0;
          scan_ctl.clear = 1'b1;
          unique case (op_in)
            OP_INSERT: begin
              done_d = 1'b1;
              if (count_q == CntW'(CAPACITY)) begin
                res_d    = '0;
                status_d = ST_FULL;
              end else begin
                we       = 1'b1;
                count_d  = count_q + 1'b1;
                res_d    = data_value_i;
                status_d = ST_OK;
              end
            end
            OP_REMOVE_MAX, OP_REMOVE_MIN: begin
              if (count_q == '0) begin
                done_d   = 1'b1;
                res_d    = '0;
                status_d = ST_EMPTY;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_SEARCH: begin
              if (count_q == '0) begin
                done_d   = 1'b1;
                res_d    = '0;
                status_d = ST_NOT_FOUND;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        smp_d     = 1'b1;
        smp_idx_d = addr_q;
        if (addr_q == last_addr) begin
          state_d = S_DRAIN;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (op_q == OP_SEARCH) begin
          done_d   = 1'b1;
          res_d    = '0;
          status_d = found ? ST_OK : ST_NOT_FOUND;
          state_d  = S_IDLE;
        end else if (best_idx == last_addr) begin
          done_d   = 1'b1;
          res_d    = best_val;
          status_d = ST_OK;
          count_d  = count_q - 1'b1;
          state_d  = S_IDLE;
        end else begin
          raddr   = last_addr;
          state_d = S_MOVE;
        end
      end
      S_MOVE: begin
        we       = 1'b1;
        waddr    = best_idx;
        wdata    = rdata;
        done_d   = 1'b1;
        res_d    = best_val;
        status_d = ST_OK;
        count_d  = count_q - 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      smp_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      smp_q   <= smp_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    addr_q    <= addr_d;
    smp_idx_q <= smp_idx_d;
    res_q     <= res_d;
    status_q  <= status_d;
  end

  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign status_o       = status_q;
  assign entry_count_o  = count_q;

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the min/max priority queue: predicted results versus DUT results.
module testbench;
  import mmpq_pkg::*;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned CountW = $clog2(QueueDepth + 1);
  localparam int unsigned RandomItems = 1950;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned DrainCycles = 100;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic [CountW-1:0]  count;
  } pq_result_t;

  class pq_tracker;
    logic signed [31:0] held[$];
    pq_result_t         pending_results[$];
    int unsigned        depth;
    int unsigned        err_count;

    function new(int unsigned depth_limit);
      depth = depth_limit;
      err_count = 0;
    endfunction

    function void note_request(op_e op, logic signed [31:0] v);
      pq_result_t  exp_res;
      int unsigned best;
      bit          want_largest;
      exp_res.value = '0;
      exp_res.status = ST_OK;
      case (op)
        OP_INSERT: begin
          if (held.size() >= depth) begin
            exp_res.status = ST_FULL;
          end else begin
            held.push_back(v);
            exp_res.value = v;
          end
        end
        OP_REMOVE_MAX, OP_REMOVE_MIN: begin
          if (held.size() == 0) begin
            exp_res.status = ST_EMPTY;
          end else begin
            want_largest = (op == OP_REMOVE_MAX);
            best = 0;
            for (int unsigned i = 1; i < held.size(); i++) begin
              if (want_largest ? (held[i] > held[best]) : (held[i] < held[best])) best = i;
            end
            exp_res.value = held[best];
            held.delete(best);
          end
        end
        default: begin
          exp_res.status = ST_NOT_FOUND;
          foreach (held[i]) begin
            if (held[i] == v) exp_res.status = ST_OK;
          end
        end
      endcase
      exp_res.count = CountW'(held.size());
      pending_results.push_back(exp_res);
    endfunction

    function void check_result(logic signed [31:0] value, logic [1:0] status,
                               logic [CountW-1:0] count);
      pq_result_t exp_res;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: value %h status %0d count %0d",
                 $time, value, status, count);
        err_count++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (value !== exp_res.value) begin
        $display("%0t: result_value expected %h actual %h", $time, exp_res.value, value);
        err_count++;
      end
      if (status !== exp_res.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status);
        err_count++;
      end
      if (count !== exp_res.count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, exp_res.count, count);
        err_count++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [1:0]         operation_i;
  logic signed [31:0] data_value_i;
  logic               done_o;
  logic signed [31:0] result_value_o;
  logic [1:0]         status_o;
  logic [CountW-1:0]  entry_count_o;

  pq_tracker   sb = new(QueueDepth);
  int unsigned idle_pct;
  bit          calm;
  int unsigned stall_cycles;

  min_max_priority_queue #(
    .CAPACITY(QueueDepth)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .data_value_i  (data_value_i),
    .done_o        (done_o),
    .result_value_o(result_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_value_o, status_o, entry_count_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("testbench failed");
        $finish;
      end
    end
  end

  // Call right after a falling edge; returns right after the falling edge that follows acceptance.
  task automatic send_request(op_e op, logic signed [31:0] v);
    if (!calm && idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start <= 1'b1;
    operation_i <= op;
    data_value_i <= v;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    sb.note_request(op, v);
    @(negedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(1) ? 32'sd0 : -32'sd1;
      3, 4, 5: return $signed($urandom_range(15)) - 32'sd8;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_search_value();
    if (sb.held.size() > 0 && $urandom_range(1))
      return sb.held[$urandom_range(sb.held.size() - 1)];
    return pick_value();
  endfunction

  initial begin
    int unsigned seg_left;
    int unsigned mode;
    int unsigned r;
    int unsigned waited;
    op_e         op;

    rst_ni = 1'b0;
    start = 1'b0;
    operation_i = OP_INSERT;
    data_value_i = '0;
    idle_pct = 0;
    calm = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_request(OP_REMOVE_MAX, 32'sd5);
    send_request(OP_REMOVE_MIN, -32'sd5);
    send_request(OP_SEARCH, 32'sd0);
    send_request(OP_INSERT, 32'sh7fffffff);
    send_request(OP_INSERT, 32'sh80000000);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_SEARCH, -32'sd1);
    send_request(OP_SEARCH, 32'sd5);
    send_request(OP_SEARCH, 32'sh80000000);
    send_request(OP_REMOVE_MAX, 32'sd0);
    send_request(OP_REMOVE_MIN, 32'sd0);
    send_request(OP_INSERT, 32'sd7);
    send_request(OP_INSERT, 32'sd7);
    send_request(OP_INSERT, -32'sd3);
    send_request(OP_INSERT, -32'sd3);
    send_request(OP_REMOVE_MAX, 32'sd0);
    send_request(OP_REMOVE_MIN, 32'sd0);
    send_request(OP_REMOVE_MAX, 32'sd0);
    send_request(OP_REMOVE_MIN, 32'sd0);
    send_request(OP_REMOVE_MAX, 32'sd0);
    send_request(OP_REMOVE_MIN, 32'sd0);
    send_request(OP_REMOVE_MIN, 32'sd0);
    send_request(OP_SEARCH, -32'sd1);

    seg_left = 0;
    mode = 0;
    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i < RandomItems / 3) idle_pct = 34;
      else if (i < 2 * RandomItems / 3) idle_pct = 51;
      else idle_pct = 0;
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 100);
        mode = $urandom_range(2);
        calm = ($urandom_range(3) == 0);
      end
      seg_left--;
      r = $urandom_range(99);
      // fill, drain, or mixed traffic per segment
      case (mode)
        0: op = (r < 85) ? OP_INSERT : op_e'($urandom_range(1, 3));
        1: op = (r < 80) ? op_e'($urandom_range(1, 2)) : op_e'($urandom_range(0, 3));
        default: op = op_e'($urandom_range(0, 3));
      endcase
      if (op == OP_SEARCH) send_request(op, pick_search_value());
      else send_request(op, pick_value());
    end
    start <= 1'b0;

    waited = 0;
    while (sb.pending_results.size() != 0 && waited < StallLimit) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending_results.size());
      sb.err_count++;
    end
    if (sb.err_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
